@@ sv/rlts_pkg.sv @@
// Shared constants and colour tables for the RGB LED table sequencer.
`default_nettype none
package rlts_pkg;

   localparam int TableRows   = 9;
   localparam int RowSelWidth = 4;
   localparam int TickWidth   = 16;
   localparam int DutyWidth   = 14;
   localparam int LevelWidth  = 4;
   localparam int RowOutWidth = 3;
   localparam int PlainWidth  = 8;

   // rows that carry each colour; the same rows are fully on in plain and fade mode
   localparam logic [TableRows-1:0] RedOn   = 9'b1_0101_0001;
   localparam logic [TableRows-1:0] GreenOn = 9'b1_0101_0010;
   localparam logic [TableRows-1:0] BlueOn  = 9'b1_0101_0100;
   // rows with the 500 tick period; the others use 100
   localparam logic [TableRows-1:0] LongRow = 9'b0_0000_0111;

   localparam logic [PlainWidth-1:0] PlainFull  = 8'd255;
   localparam logic [LevelWidth-1:0] FadeTop    = 4'd10;
   localparam logic [DutyWidth-1:0]  LevelScale = 14'd1000;

   // divisibility by an odd constant: x * inverse mod 2^16 stays at or below the bound
   localparam logic [TickWidth-1:0] Inv25    = 16'd23593;
   localparam logic [TickWidth-1:0] Bound25  = 16'd2621;
   localparam logic [TickWidth-1:0] Inv125   = 16'd30933;
   localparam logic [TickWidth-1:0] Bound125 = 16'd524;

   localparam logic CsrRegFadeMode = 1'b0;

endpackage
`default_nettype wire

@@ sv/rlts_req_if.sv @@
// Input channel carrying one tick value per beat.
`default_nettype none
interface rlts_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] tick_count;

   modport source (output valid, output tick_count, input ready);
   modport sink   (input valid, input tick_count, output ready);
endinterface
`default_nettype wire

@@ sv/rlts_rsp_if.sv @@
// Result channel carrying the duties and row index of one tick per beat.
`default_nettype none
interface rlts_rsp_if;
   logic        valid;
   logic        ready;
   logic        duty_written;
   logic [13:0] red_duty;
   logic [13:0] green_duty;
   logic [13:0] blue_duty;
   logic [2:0]  row_now;

   modport source (output valid, output duty_written, output red_duty, output green_duty,
                   output blue_duty, output row_now, input ready);
   modport sink   (input valid, input duty_written, input red_duty, input green_duty,
                   input blue_duty, input row_now, output ready);
endinterface
`default_nettype wire

@@ sv/rgb_led_table_sequencer_top.sv @@
// RGB LED table sequencer: tick-driven stepping or fading through a colour table.
//
// Each req beat carries a tick value and produces exactly one rsp beat. On
// its way from acceptance to result the first register holds the tick's
// divisibility by 100 and 500, the second holds the result, computed
// from those flags, the current row and the fade levels. The row and level
// registers update in the same cycle that a result is loaded, so a new beat is
// accepted every cycle while rsp is ready. fade_mode lives at csr address 0.
`default_nettype none
module rgb_led_table_sequencer_top #(
   parameter int ROWS_IN_USE = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   rlts_req_if.sink         req_bus,
   rlts_rsp_if.source       rsp_bus,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);

   localparam int RowWidth = (ROWS_IN_USE > 1) ? $clog2(ROWS_IN_USE) : 1;

   logic fade_mode_ff, fade_mode_in;

   logic a_valid_ff, a_valid_in;
   logic a_hit100_ff, a_hit100_in;
   logic a_hit500_ff, a_hit500_in;

   logic [RowWidth-1:0]               row_ff, row_in;
   logic [rlts_pkg::LevelWidth-1:0]   red_level_ff, red_level_in;
   logic [rlts_pkg::LevelWidth-1:0]   green_level_ff, green_level_in;
   logic [rlts_pkg::LevelWidth-1:0]   blue_level_ff, blue_level_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              written_ff, written_in;
   logic [rlts_pkg::DutyWidth-1:0]    red_ff, red_in;
   logic [rlts_pkg::DutyWidth-1:0]    green_ff, green_in;
   logic [rlts_pkg::DutyWidth-1:0]    blue_ff, blue_in;
   logic [rlts_pkg::RowOutWidth-1:0]  row_now_ff, row_now_in;

   logic                              csr_write;
   logic                              req_take;
   logic                              rsp_free;
   logic                              advance;
   logic [rlts_pkg::TickWidth-1:0]    mul25;
   logic [rlts_pkg::TickWidth-1:0]    mul125;
   logic                              tick_base;
   logic [rlts_pkg::RowSelWidth-1:0]  row_sel;
   logic                              act;
   logic [rlts_pkg::LevelWidth-1:0]   red_goal, green_goal, blue_goal;
   logic [rlts_pkg::LevelWidth-1:0]   red_step, green_step, blue_step;
   logic                              at_goal;
   logic                              move_row;
   logic [RowWidth:0]                 row_inc;
   logic [RowWidth-1:0]               row_wrap;

   function automatic logic [rlts_pkg::LevelWidth-1:0] step_toward(
      input logic [rlts_pkg::LevelWidth-1:0] level,
      input logic [rlts_pkg::LevelWidth-1:0] goal
   );
      logic [rlts_pkg::LevelWidth-1:0] result;
      result = level;
      if (level < goal) begin
         result = level + 1'b1;
      end else if (level > goal) begin
         result = level - 1'b1;
      end
      return result;
   endfunction

   // csr
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_prdata = (csr_paddr[2] == rlts_pkg::CsrRegFadeMode) ?
                       {31'd0, fade_mode_ff} : 32'd0;

   always_comb begin
      fade_mode_in = fade_mode_ff;
      if (csr_write && csr_paddr[2] == rlts_pkg::CsrRegFadeMode) begin
         fade_mode_in = csr_pwdata[0];
      end
   end

   // handshake
   assign rsp_free      = !rsp_valid_ff | rsp_bus.ready;
   assign advance       = a_valid_ff & rsp_free;
   assign req_bus.ready = !a_valid_ff | rsp_free;
   assign req_take      = req_bus.valid & req_bus.ready;

   // divisibility of the incoming tick
   assign mul25     = rlts_pkg::TickWidth'(req_bus.tick_count * rlts_pkg::Inv25);
   assign mul125    = rlts_pkg::TickWidth'(req_bus.tick_count * rlts_pkg::Inv125);
   assign tick_base = (req_bus.tick_count != '0) && (req_bus.tick_count[1:0] == 2'b00);

   always_comb begin
      a_valid_in  = a_valid_ff;
      a_hit100_in = a_hit100_ff;
      a_hit500_in = a_hit500_ff;
      if (req_take) begin
         a_valid_in  = 1'b1;
         a_hit100_in = tick_base && (mul25 <= rlts_pkg::Bound25);
         a_hit500_in = tick_base && (mul125 <= rlts_pkg::Bound125);
      end else if (advance) begin
         a_valid_in = 1'b0;
      end
   end

   // row and level update
   assign row_sel    = rlts_pkg::RowSelWidth'(row_ff);
   assign act        = rlts_pkg::LongRow[row_sel] ? a_hit500_ff : a_hit100_ff;
   assign red_goal   = rlts_pkg::RedOn[row_sel]   ? rlts_pkg::FadeTop : '0;
   assign green_goal = rlts_pkg::GreenOn[row_sel] ? rlts_pkg::FadeTop : '0;
   assign blue_goal  = rlts_pkg::BlueOn[row_sel]  ? rlts_pkg::FadeTop : '0;
   assign red_step   = step_toward(red_level_ff, red_goal);
   assign green_step = step_toward(green_level_ff, green_goal);
   assign blue_step  = step_toward(blue_level_ff, blue_goal);
   assign at_goal    = (red_step == red_goal) && (green_step == green_goal) &&
                       (blue_step == blue_goal);
   assign row_inc    = {1'b0, row_ff} + 1'b1;
   assign row_wrap   = (row_inc >= (RowWidth+1)'(ROWS_IN_USE)) ? '0 : row_inc[RowWidth-1:0];
   assign move_row   = advance && act && (!fade_mode_ff || at_goal);

   always_comb begin
      row_in         = move_row ? row_wrap : row_ff;
      red_level_in   = red_level_ff;
      green_level_in = green_level_ff;
      blue_level_in  = blue_level_ff;
      if (advance && act && fade_mode_ff) begin
         red_level_in   = red_step;
         green_level_in = green_step;
         blue_level_in  = blue_step;
      end
   end

   // result
   always_comb begin
      rsp_valid_in = advance | (rsp_valid_ff & !rsp_bus.ready);
      written_in   = written_ff;
      red_in       = red_ff;
      green_in     = green_ff;
      blue_in      = blue_ff;
      row_now_in   = row_now_ff;
      if (advance) begin
         written_in = act;
         row_now_in = rlts_pkg::RowOutWidth'(row_in);
         red_in     = '0;
         green_in   = '0;
         blue_in    = '0;
         if (act && fade_mode_ff) begin
            red_in   = rlts_pkg::DutyWidth'(red_step) * rlts_pkg::LevelScale;
            green_in = rlts_pkg::DutyWidth'(green_step) * rlts_pkg::LevelScale;
            blue_in  = rlts_pkg::DutyWidth'(blue_step) * rlts_pkg::LevelScale;
         end else if (act) begin
            red_in   = rlts_pkg::RedOn[row_sel]   ?
                       rlts_pkg::DutyWidth'(rlts_pkg::PlainFull) : '0;
            green_in = rlts_pkg::GreenOn[row_sel] ?
                       rlts_pkg::DutyWidth'(rlts_pkg::PlainFull) : '0;
            blue_in  = rlts_pkg::BlueOn[row_sel]  ?
                       rlts_pkg::DutyWidth'(rlts_pkg::PlainFull) : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fade_mode_ff   <= 1'b0;
         a_valid_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         row_ff         <= '0;
         red_level_ff   <= '0;
         green_level_ff <= '0;
         blue_level_ff  <= '0;
      end else begin
         fade_mode_ff   <= fade_mode_in;
         a_valid_ff     <= a_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         row_ff         <= row_in;
         red_level_ff   <= red_level_in;
         green_level_ff <= green_level_in;
         blue_level_ff  <= blue_level_in;
      end
   end

   always_ff @(posedge clock) begin
      a_hit100_ff <= a_hit100_in;
      a_hit500_ff <= a_hit500_in;
      written_ff  <= written_in;
      red_ff      <= red_in;
      green_ff    <= green_in;
      blue_ff     <= blue_in;
      row_now_ff  <= row_now_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.duty_written = written_ff;
   assign rsp_bus.red_duty     = red_ff;
   assign rsp_bus.green_duty   = green_ff;
   assign rsp_bus.blue_duty    = blue_ff;
   assign rsp_bus.row_now      = row_now_ff;

endmodule
`default_nettype wire
